@@ rtl/core/kpqa_pkg.sv @@
// ============================================================================
// kpqa_pkg: shared definitions for the key press qualifier
// Holds the field widths, key event codes and configuration register indexes
// used by the qualifier core and its port checker.
// ============================================================================
`default_nettype none

package kpqa_pkg;

    // Field widths.
    localparam int KEY_W   = 8;
    localparam int TICK_W  = 16;
    localparam int TPS_W   = 15;
    localparam int EVENT_W = 3;
    localparam int IDX_W   = 3;

    // Stream data widths, rounded up to whole bytes.
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 8;

    // Key event codes.
    localparam logic [EVENT_W-1:0] EV_NONE  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_UP    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_DOWN  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_MODE  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_POWER = 3'd4;
    localparam logic [EVENT_W-1:0] EV_COMBO = 3'd5;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_UP_MASK    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_DOWN_MASK  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_MODE_MASK  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_POWER_MASK = 3'd3;
    localparam logic [IDX_W-1:0] CFG_TPS        = 3'd4;

endpackage

`default_nettype wire

@@ rtl/core/key_press_qualifier_autorepeat_top.sv @@
// ============================================================================
// key_press_qualifier_autorepeat_top: touch key qualifier with auto-repeat
// Turns key vector samples into key events: release events, long-press
// auto-repeat for up and down, and a one-shot up+down combo hold event.
// ============================================================================
// A sample is held in the input register, and its event in the output register.
// Throughput: one sample per cycle; while a result waits on the output, the
// input register takes one more sample and then the input side stalls.
// Reset: synchronous, active low; clears the key history and both timers,
// empties both registers and loads the default key masks and 1000 ticks/s.
`default_nettype none

module key_press_qualifier_autorepeat_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration write port.
    input  wire logic                           i_cfg_we,
    input  wire logic [kpqa_pkg::IDX_W-1:0]     i_cfg_addr,
    input  wire logic [kpqa_pkg::TPS_W-1:0]     i_cfg_wdata,
    // Input samples.
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [kpqa_pkg::S_DATA_W-1:0]  s_axis_tdata,  // key_bits[7:0], tick_now[23:8]
    // Key events.
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [kpqa_pkg::M_DATA_W-1:0]       m_axis_tdata   // key_event[2:0], zero[7:3]
);

    // Configuration registers.
    logic [kpqa_pkg::KEY_W-1:0]  r_up_mask;
    logic [kpqa_pkg::KEY_W-1:0]  r_down_mask;
    logic [kpqa_pkg::KEY_W-1:0]  r_mode_mask;
    logic [kpqa_pkg::KEY_W-1:0]  r_power_mask;
    logic [kpqa_pkg::TPS_W-1:0]  r_tps;

    // Pipeline registers.
    logic                          r_in_valid;
    logic [kpqa_pkg::KEY_W-1:0]    r_in_keys;
    logic [kpqa_pkg::TICK_W-1:0]   r_in_tick;
    logic                          r_out_valid;
    logic [kpqa_pkg::EVENT_W-1:0]  r_out_event;

    // Qualifier state.
    logic [kpqa_pkg::KEY_W-1:0]   r_prev_keys;
    logic [kpqa_pkg::TICK_W-1:0]  r_press_start;
    logic                         r_long_hold;
    logic [kpqa_pkg::TICK_W-1:0]  r_combo_start;
    logic                         r_combo_fired;

    logic [kpqa_pkg::TICK_W-1:0]   n_press_start;
    logic                          n_long_hold;
    logic [kpqa_pkg::TICK_W-1:0]   n_combo_start;
    logic                          n_combo_fired;
    logic [kpqa_pkg::EVENT_W-1:0]  n_event;

    logic                          out_ready;
    logic                          advance;
    logic [kpqa_pkg::TICK_W-1:0]   press_elapsed;
    logic [kpqa_pkg::TICK_W-1:0]   combo_elapsed;
    logic [kpqa_pkg::TICK_W-1:0]   tps_ext;
    logic [kpqa_pkg::TICK_W-1:0]   quarter_tps;
    logic [kpqa_pkg::TICK_W:0]     combo_limit;
    logic                          is_release;
    logic                          is_hold;
    logic                          hold_long;

    // Handshake: the output register frees up when empty or taken, and the
    // input register moves on whenever the output register can load.
    assign out_ready     = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_ready;
    assign s_axis_tready = !r_in_valid || out_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(kpqa_pkg::M_DATA_W - kpqa_pkg::EVENT_W){1'b0}}, r_out_event};

    // Tick arithmetic; differences wrap modulo 2^16.
    assign press_elapsed = r_in_tick - r_press_start;
    assign combo_elapsed = r_in_tick - r_combo_start;
    assign tps_ext       = {1'b0, r_tps};
    assign quarter_tps   = tps_ext >> 2;
    assign combo_limit   = {1'b0, tps_ext} + {tps_ext, 1'b0};
    assign is_release    = (r_prev_keys != '0) && (r_in_keys == '0);
    assign is_hold       = (r_prev_keys != '0) && (r_prev_keys == r_in_keys);
    assign hold_long     = r_long_hold || (press_elapsed > tps_ext);

    // Event and next-state logic for the sample in the input register.
    always_comb begin
        n_event       = kpqa_pkg::EV_NONE;
        n_press_start = r_press_start;
        n_long_hold   = r_long_hold;
        n_combo_start = r_combo_start;
        n_combo_fired = r_combo_fired;

        if (is_release) begin
            // Release of a single key; up and down stay quiet after a long hold.
            if (r_prev_keys == r_up_mask) begin
                if (!r_long_hold) begin
                    n_event = kpqa_pkg::EV_UP;
                end
            end else if (r_prev_keys == r_down_mask) begin
                if (!r_long_hold) begin
                    n_event = kpqa_pkg::EV_DOWN;
                end
            end else if (r_prev_keys == r_mode_mask) begin
                n_event = kpqa_pkg::EV_MODE;
            end else if (r_prev_keys == r_power_mask) begin
                n_event = kpqa_pkg::EV_POWER;
            end
            n_press_start = r_in_tick;
            n_long_hold   = 1'b0;
        end else if (is_hold) begin
            // Same keys still down: long-press detection and auto-repeat.
            n_long_hold = hold_long;
            if (hold_long && (press_elapsed > quarter_tps)) begin
                n_press_start = r_in_tick;
                if (r_prev_keys == r_up_mask) begin
                    n_event = kpqa_pkg::EV_UP;
                end else if (r_prev_keys == r_down_mask) begin
                    n_event = kpqa_pkg::EV_DOWN;
                end
            end
        end else begin
            n_press_start = r_in_tick;
            n_long_hold   = 1'b0;
        end

        // Combo hold of up and down together overrides any other event.
        if (r_in_keys == (r_up_mask | r_down_mask)) begin
            if (({1'b0, combo_elapsed} >= combo_limit) && !r_combo_fired) begin
                n_combo_fired = 1'b1;
                n_event       = kpqa_pkg::EV_COMBO;
            end
        end else begin
            n_combo_fired = 1'b0;
            n_combo_start = r_in_tick;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_mask    <= 8'd1;
            r_down_mask  <= 8'd2;
            r_mode_mask  <= 8'd4;
            r_power_mask <= 8'd8;
            r_tps        <= 15'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                kpqa_pkg::CFG_UP_MASK:    r_up_mask    <= i_cfg_wdata[kpqa_pkg::KEY_W-1:0];
                kpqa_pkg::CFG_DOWN_MASK:  r_down_mask  <= i_cfg_wdata[kpqa_pkg::KEY_W-1:0];
                kpqa_pkg::CFG_MODE_MASK:  r_mode_mask  <= i_cfg_wdata[kpqa_pkg::KEY_W-1:0];
                kpqa_pkg::CFG_POWER_MASK: r_power_mask <= i_cfg_wdata[kpqa_pkg::KEY_W-1:0];
                kpqa_pkg::CFG_TPS:        r_tps        <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_keys <= s_axis_tdata[kpqa_pkg::KEY_W-1:0];
            r_in_tick <= s_axis_tdata[kpqa_pkg::KEY_W +: kpqa_pkg::TICK_W];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_event <= n_event;
        end
    end

    // Qualifier state, updated once per sample as it leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_keys   <= '0;
            r_press_start <= '0;
            r_long_hold   <= 1'b0;
            r_combo_start <= '0;
            r_combo_fired <= 1'b0;
        end else if (advance) begin
            r_prev_keys   <= r_in_keys;
            r_press_start <= n_press_start;
            r_long_hold   <= n_long_hold;
            r_combo_start <= n_combo_start;
            r_combo_fired <= n_combo_fired;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/kpqa_checker.sv @@
// ============================================================================
// kpqa_checker: port-level checks for the key press qualifier
// Watches the top level's stream ports and flags protocol or range slips.
// ============================================================================
`default_nettype none

module kpqa_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [kpqa_pkg::M_DATA_W-1:0]  m_axis_tdata
);

    // A stalled result holds its value until it is transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed or dropped while stalled");

    // Only defined event codes appear, and the padding bits stay zero.
    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[kpqa_pkg::EVENT_W-1:0] <= kpqa_pkg::EV_COMBO
                           && m_axis_tdata[kpqa_pkg::M_DATA_W-1:kpqa_pkg::EVENT_W] == '0))
        else $error("undefined key event on the output");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending right after reset");

    // With no result waiting, the input side is never stalled.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output");

endmodule

bind key_press_qualifier_autorepeat_top kpqa_checker u_kpqa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ tb/key_press_qualifier_autorepeat_checker.sv @@
// ============================================================================
// key_press_qualifier_autorepeat_checker: port checker for the key qualifier
// Watches the configuration port and both stream channels, keeps its own
// copy of the key history, hold timers and register values, predicts one key
// event per accepted sample and compares every result transfer against the
// oldest prediction still waiting.
// ============================================================================
module key_press_qualifier_autorepeat_checker import kpqa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [IDX_W-1:0]    i_cfg_addr,
    input  logic [TPS_W-1:0]    i_cfg_wdata,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // key_bits[7:0], tick_now[23:8]
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [M_DATA_W-1:0] m_axis_tdata,   // key_event[2:0], zero[7:3]
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_event_count,
    output int                  o_key_event_count,
    output int                  o_combo_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Register copies.
    logic [KEY_W-1:0]   up_mask;
    logic [KEY_W-1:0]   down_mask;
    logic [KEY_W-1:0]   mode_mask;
    logic [KEY_W-1:0]   power_mask;
    logic [TPS_W-1:0]   tick_rate;

    // Qualifier state.
    logic [KEY_W-1:0]   key_history;
    logic [TICK_W-1:0]  press_tick;
    logic               long_held;
    logic [TICK_W-1:0]  combo_tick;
    logic               combo_done;

    // Events predicted but not yet seen on the output, oldest first.
    logic [EVENT_W-1:0] pending_events[$];
    logic [EVENT_W-1:0] predicted;
    logic [EVENT_W-1:0] want;

    // One line per mismatch, capped so a broken block cannot flood the log.
    task automatic report_mismatch(input string what);
        if (o_fail_count < 40) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
        o_fail_count++;
    endtask

    // Advance the qualifier by one sample and return the event it causes.
    task automatic qualify_sample(input logic [KEY_W-1:0] keys,
                                  input logic [TICK_W-1:0] now,
                                  output logic [EVENT_W-1:0] ev);
        logic [TICK_W-1:0] held;
        logic [TICK_W-1:0] combo_held;
        int unsigned       combo_limit;
        ev = EV_NONE;
        held = now - press_tick;
        if (key_history != '0 && keys == '0) begin
            // Release: the first matching mask in priority order decides.
            if (key_history == up_mask) begin
                if (!long_held) ev = EV_UP;
            end else if (key_history == down_mask) begin
                if (!long_held) ev = EV_DOWN;
            end else if (key_history == mode_mask) begin
                ev = EV_MODE;
            end else if (key_history == power_mask) begin
                ev = EV_POWER;
            end
            press_tick = now;
            long_held = 1'b0;
        end else if (key_history != '0 && key_history == keys) begin
            // Same keys still held: long-press detection and auto-repeat.
            if (!long_held && held > tick_rate) long_held = 1'b1;
            if (long_held && held > tick_rate / 4) begin
                press_tick = now;
                if (key_history == up_mask) begin
                    ev = EV_UP;
                end else if (key_history == down_mask) begin
                    ev = EV_DOWN;
                end
            end
        end else begin
            press_tick = now;
            long_held = 1'b0;
        end

        // The up+down combo is one-shot and overrides any other event.
        if (keys == (up_mask | down_mask)) begin
            combo_held = now - combo_tick;
            combo_limit = 3 * tick_rate;
            if (combo_held >= combo_limit && !combo_done) begin
                combo_done = 1'b1;
                ev = EV_COMBO;
            end
        end else begin
            combo_done = 1'b0;
            combo_tick = now;
        end
        key_history = keys;
    endtask

    // Track register writes, predict on input transfers, check output transfers.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            up_mask           = 8'd1;
            down_mask         = 8'd2;
            mode_mask         = 8'd4;
            power_mask        = 8'd8;
            tick_rate         = 15'd1000;
            key_history       = '0;
            press_tick        = '0;
            long_held         = 1'b0;
            combo_tick        = '0;
            combo_done        = 1'b0;
            pending_events.delete();
            o_fail_count      = 0;
            o_event_count     = 0;
            o_key_event_count = 0;
            o_combo_count     = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_UP_MASK:    up_mask = i_cfg_wdata[KEY_W-1:0];
                    CFG_DOWN_MASK:  down_mask = i_cfg_wdata[KEY_W-1:0];
                    CFG_MODE_MASK:  mode_mask = i_cfg_wdata[KEY_W-1:0];
                    CFG_POWER_MASK: power_mask = i_cfg_wdata[KEY_W-1:0];
                    CFG_TPS:        tick_rate = i_cfg_wdata;
                    default:        ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                qualify_sample(s_axis_tdata[KEY_W-1:0], s_axis_tdata[KEY_W +: TICK_W],
                               predicted);
                pending_events.push_back(predicted);
            end

            if (m_axis_tvalid && m_axis_tready) begin
                o_event_count++;
                if (pending_events.size() == 0) begin
                    report_mismatch($sformatf("event %0d with no sample waiting",
                                              m_axis_tdata[EVENT_W-1:0]));
                end else begin
                    want = pending_events.pop_front();
                    if (m_axis_tdata[EVENT_W-1:0] != want) begin
                        report_mismatch($sformatf("result %0d: key_event %0d, expected %0d",
                                                  o_event_count,
                                                  m_axis_tdata[EVENT_W-1:0], want));
                    end
                    if (m_axis_tdata[M_DATA_W-1:EVENT_W] != '0) begin
                        report_mismatch($sformatf("result %0d: padding bits 0x%0h not zero",
                                                  o_event_count,
                                                  m_axis_tdata[M_DATA_W-1:EVENT_W]));
                    end
                    if (want == EV_COMBO) begin
                        o_combo_count++;
                    end else if (want != EV_NONE) begin
                        o_key_event_count++;
                    end
                end
            end
        end
        o_pending = pending_events.size();
    end

endmodule

@@ tb/tb_key_press_qualifier_autorepeat_top.sv @@
// ============================================================================
// tb_key_press_qualifier_autorepeat_top: testbench for the key qualifier
// Drives directed key sequences and then random press, hold, combo and noise
// sequences over several register settings and handshake pacing modes; the
// checker predicts and compares every event, this module gives the verdict.
// ============================================================================
module tb_key_press_qualifier_autorepeat_top;
    timeunit 1ns;
    timeprecision 1ps;
    import kpqa_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_SAMPLES  = 210;
    localparam int HOLD_OFF_LEN   = 120;
    localparam logic [IDX_W-1:0] CFG_FIRST_UNUSED = CFG_TPS + 3'd1;

    typedef enum int {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_e;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [IDX_W-1:0]    i_cfg_addr = '0;
    logic [TPS_W-1:0]    i_cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;   // key_bits[7:0], tick_now[23:8]
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;        // key_event[2:0], zero[7:3]

    int fail_count;
    int pending;
    int event_count;
    int key_event_count;
    int combo_count;

    // Stimulus state: current tick and the settings the sequences aim at.
    logic [TICK_W-1:0] sample_tick = '0;
    logic [KEY_W-1:0]  up_key = 8'h01;
    logic [KEY_W-1:0]  down_key = 8'h02;
    logic [TPS_W-1:0]  ticks_per_sec = 15'd1000;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                samples_sent = 0;
    int                phase_end;
    int                cycle_count = 0;
    logic              hold_go = 1'b0;
    logic              hold_started = 1'b0;
    int                hold_left = 0;
    logic              mid_drain_done = 1'b0;

    key_press_qualifier_autorepeat_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    key_press_qualifier_autorepeat_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_event_count     (event_count),
        .o_key_event_count (key_event_count),
        .o_combo_count     (combo_count)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_key_press_qualifier_autorepeat_top: FAIL");
            $finish;
        end
    end

    // Event receiver: random stalls, plus one long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_go && !hold_started) begin
            hold_started = 1'b1;
            hold_left = HOLD_OFF_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Offer one sample, with random idle cycles first, and wait for the transfer.
    task automatic send_sample(input logic [KEY_W-1:0] keys, input logic [TICK_W-1:0] tick);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {tick, keys};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        samples_sent++;
    endtask

    // Random tick advance: sometimes none, sometimes the full scale.
    function automatic int unsigned tick_step(input int unsigned scale);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return scale;
        return $urandom_range(1, scale);
    endfunction

    // Hold one key vector for a number of samples with advancing ticks.
    task automatic press_run(input logic [KEY_W-1:0] keys, input int count,
                             input int unsigned scale);
        repeat (count) begin
            sample_tick = sample_tick + 16'(tick_step(scale));
            send_sample(keys, sample_tick);
        end
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2: return up_key;
            3, 4:    return down_key;
            5:       return 8'h04 << $urandom_range(0, 1);
            6:       return up_key | down_key;
            7:       return 8'($urandom);
            default: return 8'(1 << $urandom_range(0, 7));
        endcase
    endfunction

    // One well-formed or deliberately broken key sequence.
    task automatic run_sequence();
        int          kind;
        int unsigned quarter;
        int unsigned third;
        int unsigned whole;
        logic [KEY_W-1:0] keys;
        kind = $urandom_range(0, 99);
        quarter = ticks_per_sec / 4 + 1;
        third = ticks_per_sec / 3 + 1;
        whole = ticks_per_sec + 1;
        if (kind < 30) begin
            // Short tap.
            press_run(pick_key(), $urandom_range(1, 4), quarter);
            press_run(8'h00, 1, quarter);
        end else if (kind < 55) begin
            // Long hold, mostly on up or down to get auto-repeat.
            if ($urandom_range(0, 3) != 0) begin
                keys = $urandom_range(0, 1) ? up_key : down_key;
            end else begin
                keys = pick_key();
            end
            press_run(keys, $urandom_range(3, 14), third);
            press_run(8'h00, 1, quarter);
        end else if (kind < 70) begin
            // Combo hold, sometimes falling back to a single key.
            press_run(up_key | down_key, $urandom_range(4, 10), whole);
            if ($urandom_range(0, 1) != 0) press_run(up_key, $urandom_range(1, 3), third);
            press_run(8'h00, 1, quarter);
        end else if (kind < 82) begin
            // Key change in the middle of a hold.
            press_run(pick_key(), $urandom_range(1, 5), third);
            press_run(pick_key(), $urandom_range(1, 5), third);
            press_run(8'h00, 1, quarter);
        end else if (kind < 90) begin
            press_run(8'h00, $urandom_range(1, 3), whole);
        end else begin
            // Noise: random vectors at random ticks.
            repeat ($urandom_range(1, 4)) begin
                sample_tick = 16'($urandom);
                send_sample(8'($urandom), sample_tick);
            end
        end
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [TPS_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // Write all registers, with junk in the unused upper mask bits, and one
    // write to an unused index.
    task automatic set_config(input logic [KEY_W-1:0] up, input logic [KEY_W-1:0] dn,
                              input logic [KEY_W-1:0] md, input logic [KEY_W-1:0] pw,
                              input logic [TPS_W-1:0] tps);
        cfg_write(CFG_UP_MASK, {7'($urandom_range(0, 127)), up});
        cfg_write(CFG_DOWN_MASK, {7'($urandom_range(0, 127)), dn});
        cfg_write(CFG_MODE_MASK, {7'($urandom_range(0, 127)), md});
        cfg_write(CFG_POWER_MASK, {7'($urandom_range(0, 127)), pw});
        cfg_write(CFG_TPS, tps);
        cfg_write(CFG_FIRST_UNUSED + 3'($urandom_range(0, 2)), 15'($urandom));
        i_cfg_we <= 1'b0;
        up_key = up;
        down_key = dn;
        ticks_per_sec = tps;
    endtask

    // Wait until every predicted event has been seen, then let the pipe settle.
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_pacing(input pace_e mode);
        case (mode)
            PACE_FREE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            PACE_SEND_IDLE:  begin send_idle_pct = 74; recv_stall_pct = 0;  end
            PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default:         begin send_idle_pct = 37; recv_stall_pct = 37; end
        endcase
    endtask

    task automatic configure_phase(input int p);
        case (p)
            0: set_config(8'h01, 8'h02, 8'h04, 8'h08, 15'd1000);
            1: set_config(8'h80, 8'h40, 8'h20, 8'h10, 15'd4);
            2: set_config(8'(1 << $urandom_range(0, 7)), 8'(1 << $urandom_range(0, 7)),
                          8'(1 << $urandom_range(0, 7)), 8'(1 << $urandom_range(0, 7)),
                          15'd21845);
            3: set_config(8'h00, 8'hFF, 8'h03, 8'h03, 15'd0);
            4: set_config(8'h01, 8'h02, 8'h04, 8'h08, 15'h7FFF);
            5: set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          15'($urandom_range(4, 60)));
            6: set_config(8'h05, 8'h05, 8'h05, 8'h0A, 15'd7);
            default: set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                15'($urandom_range(4, 21845)));
        endcase
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset settings: masks 1, 2, 4, 8 and 1000 ticks/s.
        send_sample(8'h00, 16'd0);        // nothing pressed, no event
        send_sample(8'h01, 16'd10);       // up tap
        send_sample(8'h00, 16'd20);
        send_sample(8'h02, 16'd30);       // down tap
        send_sample(8'h00, 16'd40);
        send_sample(8'h04, 16'd50);       // mode tap
        send_sample(8'h00, 16'd60);
        send_sample(8'h08, 16'd70);       // power tap
        send_sample(8'h00, 16'd80);
        send_sample(8'hFF, 16'd90);       // vector matching no key
        send_sample(8'h00, 16'd100);
        // Long press: exactly one second is not enough, one tick more is.
        send_sample(8'h01, 16'd200);
        send_sample(8'h01, 16'd1200);
        send_sample(8'h01, 16'd1201);
        send_sample(8'h01, 16'd1451);     // repeat interval not yet exceeded
        send_sample(8'h01, 16'd1452);
        send_sample(8'h00, 16'd1500);     // release after long hold is silent
        // Combo fires at exactly three seconds, and only once.
        send_sample(8'h03, 16'd2000);
        send_sample(8'h03, 16'd4499);
        send_sample(8'h03, 16'd4500);
        send_sample(8'h03, 16'd4600);
        send_sample(8'h00, 16'd4700);
        // Hold across the tick wrap.
        send_sample(8'h02, 16'hFFFF);
        send_sample(8'h02, 16'h03FF);
        send_sample(8'h00, 16'h0400);
        s_axis_tvalid <= 1'b0;
        drain();

        // Equal masks resolve to up; the combo wins over an auto-repeat.
        set_config(8'h11, 8'h00, 8'h11, 8'h11, 15'd1000);
        send_sample(8'h11, 16'd5001);
        send_sample(8'h00, 16'd5002);
        send_sample(8'h11, 16'd6001);
        send_sample(8'h11, 16'd9001);
        send_sample(8'h00, 16'd9100);
        s_axis_tvalid <= 1'b0;

        // Random phases over several settings and pacing modes.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain();
            set_pacing(pace_e'(p % 4));
            configure_phase(p);
            phase_end = samples_sent + PHASE_SAMPLES;
            while (samples_sent < phase_end) begin
                run_sequence();
                if (p == 0 && !hold_go && samples_sent > phase_end - 160) begin
                    hold_go = 1'b1;
                end
                if (p == 4 && !mid_drain_done && samples_sent > phase_end - 110) begin
                    s_axis_tvalid <= 1'b0;
                    drain();
                    mid_drain_done = 1'b1;
                end
            end
            s_axis_tvalid <= 1'b0;
        end

        drain();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d key samples across %0d register settings and four pacing modes.",
                 samples_sent, PHASE_COUNT + 2);
        $display("Checked %0d results: %0d key events, %0d combo holds, %0d mismatches.",
                 event_count, key_event_count, combo_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_key_press_qualifier_autorepeat_top: PASS");
        end else begin
            $display("tb_key_press_qualifier_autorepeat_top: FAIL");
        end
        $finish;
    end

endmodule
